### rtl/bpfa_pkg.sv
`default_nettype none

package bpfa_pkg;

    localparam int unsigned BITS_PER_WORD     = 64;
    localparam int unsigned DEF_BITMAP_WORDS  = 16384;
    localparam int unsigned DEF_FRAME_BYTES   = 4096;
    localparam int unsigned ADDR_W            = 32;
    localparam int unsigned COUNT_W           = 21;

    typedef enum logic
    {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } bpfa_action_t;

    typedef struct packed
    {
        bpfa_action_t        action;
        logic [ADDR_W-1:0]   frame_address;
    } bpfa_req_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]   alloc_address;
        logic                found;
        logic [COUNT_W-1:0]  free_count;
    } bpfa_rsp_t;

    // lowest set bit of a word, zero when none
    function automatic logic [5:0] first_set64(input logic [63:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/bitmap_page_frame_allocator.sv
`default_nettype none

// channel | signals                          | beat
// --------+----------------------------------+---------------------------------------
// request | req_valid, req_ready, req        | action, frame_address
// response| rsp_valid, rsp_ready, rsp        | alloc_address, found, free_count
//
// steps: allocate is summary read, bitmap read, write back, result, the two reads
//   of the summary and bitmap memories being dependent; a failed allocate goes
//   straight to the result; free is divide, read, write back, result, the divide a
//   shift with a power-of-two frame size, else steps of 8 quotient bits each
// reset: after rst_n rises a clearing pass over all BITMAP_WORDS words fills the bitmap
//   with ones and the summary memory with zeros; req_ready stays low meanwhile
// stalls: the response register holds a finished beat while the next request is
//   taken; only the result step waits for rsp_ready
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int unsigned BITMAP_WORDS = DEF_BITMAP_WORDS,
    parameter int unsigned FRAME_BYTES  = DEF_FRAME_BYTES
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire bpfa_req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output bpfa_rsp_t      rsp
);

    // geometry: bitmap words, summary words (one bit per bitmap word), summary groups
    localparam int unsigned TOTAL   = BITMAP_WORDS * BITS_PER_WORD;
    localparam int unsigned WW      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int unsigned FW      = WW + 6;
    localparam int unsigned S1      = (BITMAP_WORDS + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int unsigned SW      = (S1 > 1) ? $clog2(S1) : 1;
    localparam int unsigned S2      = (S1 + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int unsigned GIW     = (S2 > 1) ? $clog2(S2) : 1;
    localparam int unsigned L2BITS  = S2 * BITS_PER_WORD;
    localparam int unsigned L2IW    = $clog2(L2BITS);
    localparam int unsigned CW      = $clog2(TOTAL + 1);
    // frame size divider
    localparam bit          IS_POW2 = (FRAME_BYTES & (FRAME_BYTES - 1)) == 0;
    localparam int unsigned FB_LOG  = $clog2(FRAME_BYTES);
    localparam int unsigned RW      = FB_LOG;
    localparam int unsigned DIV_STEPS = 8;
    localparam int unsigned DIV_LAST  = ADDR_W / DIV_STEPS - 1;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_A_MAP,
        ST_A_MOD,
        ST_F_DIV,
        ST_F_RD,
        ST_F_MOD,
        ST_RESULT
    } state_t;

    state_t             state_reg;
    logic [WW-1:0]      clr_reg;
    logic [WW-1:0]      w_reg;
    logic [5:0]         b_reg;
    logic [SW-1:0]      s_reg;
    logic [FW-1:0]      frame_reg;
    logic               found_reg;
    logic [CW-1:0]      cnt_reg;
    logic [L2BITS-1:0]  l2_reg;
    logic [ADDR_W-1:0]  quot_reg;
    logic [RW-1:0]      rem_reg;
    logic [1:0]         div_cnt_reg;
    logic               rsp_valid_reg;
    bpfa_rsp_t          rsp_reg;

    // bitmap: set bit = frame in use; summary: set bit = bitmap word has a free frame
    logic [63:0] map_mem [BITMAP_WORDS];
    logic [63:0] sum_mem [S1];
    logic [63:0] map_q;
    logic [63:0] sum_q;

    logic          map_we;
    logic [WW-1:0] map_waddr;
    logic [WW-1:0] map_raddr;
    logic [63:0]   map_wdata;
    logic          sum_we;
    logic [SW-1:0] sum_waddr;
    logic [SW-1:0] sum_raddr;
    logic [63:0]   sum_wdata;

    // summary group search, done on flops during idle
    logic [S2-1:0]   grp_any;
    logic [GIW-1:0]  grp_sel;
    logic [63:0]     grp_word;
    logic [SW-1:0]   s_pick;
    logic            any_free;

    logic [5:0]      t_bit;
    logic [5:0]      b_bit;
    logic [WW-1:0]   w_alloc;
    logic [63:0]     map_alloc;
    logic [63:0]     sum_alloc;
    logic            word_full;
    logic [ADDR_W-1:0] div_q;
    logic [RW-1:0]     div_r;
    logic            clr_in_sum;
    logic            rsp_load;
    logic [ADDR_W-1:0] addr_prod;

    always_comb
    begin
        grp_any = '0;
        for (int gi = 0; gi < S2; gi++)
        begin
            grp_any[gi] = |l2_reg[gi*BITS_PER_WORD +: BITS_PER_WORD];
        end
        grp_sel = '0;
        for (int gi = S2 - 1; gi >= 0; gi--)
        begin
            if (grp_any[gi])
            begin
                grp_sel = GIW'(gi);
            end
        end
        any_free = |grp_any;
        grp_word = l2_reg[grp_sel*BITS_PER_WORD +: BITS_PER_WORD];
        s_pick   = SW'({grp_sel, first_set64(grp_word)});
    end

    // lowest non-full word under the summary bit, lowest free frame in that word
    assign t_bit     = first_set64(sum_q);
    assign b_bit     = first_set64(~map_q);
    assign w_alloc   = WW'({s_reg, t_bit});
    assign map_alloc = map_q | (64'd1 << b_bit);
    assign word_full = &map_alloc;
    assign sum_alloc = sum_q & ~(64'd1 << t_bit);

    // divide by the frame size: shift, or 8 restoring steps per cycle
    always_comb
    begin
        logic [RW:0]       rs;
        logic [ADDR_W-1:0] q;
        logic [RW-1:0]     r;
        rs = '0;
        q  = quot_reg;
        r  = rem_reg;
        if (IS_POW2)
        begin
            q = quot_reg >> FB_LOG;
        end
        else
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                rs = {r, q[ADDR_W-1]};
                q  = {q[ADDR_W-2:0], 1'b0};
                if (rs >= (RW+1)'(FRAME_BYTES))
                begin
                    rs   = rs - (RW+1)'(FRAME_BYTES);
                    q[0] = 1'b1;
                end
                r = rs[RW-1:0];
            end
        end
        div_q = q;
        div_r = r;
    end

    assign clr_in_sum = 32'(clr_reg) < 32'(S1);

    // memory port steering
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = w_reg;
        map_wdata = map_q & ~(64'd1 << b_reg);
        sum_we    = 1'b0;
        sum_waddr = s_reg;
        sum_wdata = sum_q | (64'd1 << 6'(w_reg));
        map_raddr = (state_reg == ST_A_MAP) ? w_alloc : w_reg;
        sum_raddr = (state_reg == ST_IDLE) ? s_pick : s_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '1;
                sum_we    = clr_in_sum;
                sum_waddr = SW'(clr_reg);
                sum_wdata = '0;
            end
            ST_A_MOD:
            begin
                map_we    = 1'b1;
                map_wdata = map_alloc;
                sum_we    = word_full;
                sum_wdata = sum_alloc;
            end
            ST_F_MOD:
            begin
                map_we = 1'b1;
                sum_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_q <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_q <= sum_mem[sum_raddr];
    end

    assign rsp_load  = (state_reg == ST_RESULT) && (!rsp_valid_reg || rsp_ready);
    assign addr_prod = 32'(frame_reg) * 32'(FRAME_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            w_reg         <= '0;
            b_reg         <= '0;
            s_reg         <= '0;
            frame_reg     <= '0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            l2_reg        <= '0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            div_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_ready && !rsp_load)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == WW'(BITMAP_WORDS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        found_reg <= 1'b0;
                        if (req.action == ACT_ALLOC)
                        begin
                            s_reg     <= s_pick;
                            state_reg <= any_free ? ST_A_MAP : ST_RESULT;
                        end
                        else
                        begin
                            quot_reg    <= req.frame_address;
                            rem_reg     <= '0;
                            div_cnt_reg <= '0;
                            state_reg   <= ST_F_DIV;
                        end
                    end
                end
                ST_A_MAP:
                begin
                    w_reg     <= w_alloc;
                    state_reg <= ST_A_MOD;
                end
                ST_A_MOD:
                begin
                    frame_reg <= FW'({w_reg, b_bit});
                    found_reg <= 1'b1;
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    // word now full and last in its summary word: drop the group bit
                    if (word_full && (sum_alloc == '0))
                    begin
                        l2_reg[L2IW'(s_reg)] <= 1'b0;
                    end
                    state_reg <= ST_RESULT;
                end
                ST_F_DIV:
                begin
                    quot_reg    <= div_q;
                    rem_reg     <= div_r;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (IS_POW2 || (div_cnt_reg == 2'(DIV_LAST)))
                    begin
                        w_reg <= div_q[6 +: WW];
                        b_reg <= div_q[5:0];
                        s_reg <= SW'(div_q[6 +: WW] >> 6);
                        // frame beyond the bitmap: no change
                        state_reg <= (div_q < ADDR_W'(TOTAL)) ? ST_F_RD : ST_RESULT;
                    end
                end
                ST_F_RD:
                begin
                    state_reg <= ST_F_MOD;
                end
                ST_F_MOD:
                begin
                    // freeing a free frame still counts
                    if (cnt_reg != CW'(TOTAL))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    l2_reg[L2IW'(s_reg)] <= 1'b1;
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (rsp_load)
                    begin
                        rsp_valid_reg         <= 1'b1;
                        rsp_reg.alloc_address <= found_reg ? addr_prod : '0;
                        rsp_reg.found         <= found_reg;
                        rsp_reg.free_count    <= COUNT_W'(cnt_reg);
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // count never runs past the number of frames
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TOTAL))
        else $error("free count above total");

    // a free frame under the summary implies a positive count
    a_count_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_MOD) |-> (cnt_reg != '0))
        else $error("allocation with zero free count");

    // failed or free beats carry a zero address
    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |-> (rsp.alloc_address == '0))
        else $error("address on a beat without a frame");

    // a result is only loaded from the result step
    a_load_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(state_reg) == ST_RESULT))
        else $error("response raised outside result step");

endmodule

`default_nettype wire

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    // block geometry, kept at the package defaults
    localparam int unsigned WORDS        = DEF_BITMAP_WORDS;
    localparam int unsigned FRAME_SZ     = DEF_FRAME_BYTES;
    localparam int unsigned FRAMES       = WORDS * BITS_PER_WORD;
    localparam int unsigned RANDOM_BEATS = 1300;
    localparam int unsigned PHASES       = 4;
    // clearing pass plus every beat at its slowest, taken many times over
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned MAX_PRINTS   = 30;

    // mirror of the frame bitmap and free count, plus the responses still owed
    class frame_alloc_scoreboard;
        bit [63:0]       usage [WORDS];
        longint unsigned free_frames;
        int unsigned     lowest_open_word;
        bpfa_rsp_t       owed_rsp [$];
        int unsigned     mismatches;

        function new();
            foreach (usage[i])
            begin
                usage[i] = '1;
            end
            free_frames      = 0;
            lowest_open_word = 0;
            mismatches       = 0;
        endfunction

        function int unsigned outstanding();
            return owed_rsp.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
            begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endtask

        // work out the response that one accepted request beat must give
        function void note_request(bpfa_req_t r);
            bpfa_rsp_t       want;
            longint unsigned addr64;
            longint unsigned frame;
            longint unsigned w;
            int unsigned     b;
            want = '0;
            if (r.action == ACT_ALLOC)
            begin
                // words below the hint are known to be full
                for (w = lowest_open_word; w < WORDS; w++)
                begin
                    if (usage[w] != '1)
                    begin
                        break;
                    end
                end
                lowest_open_word = int'(w);
                if (w < WORDS)
                begin
                    b = 0;
                    while (b < 63 && usage[w][b])
                    begin
                        b++;
                    end
                    usage[w][b] = 1'b1;
                    if (free_frames > 0)
                    begin
                        free_frames--;
                    end
                    want.alloc_address = ADDR_W'((w * BITS_PER_WORD + b) * FRAME_SZ);
                    want.found         = 1'b1;
                end
            end
            else
            begin
                addr64 = r.frame_address;
                frame  = addr64 / FRAME_SZ;
                w      = frame / BITS_PER_WORD;
                b      = int'(frame % BITS_PER_WORD);
                if (w < WORDS)
                begin
                    // freeing a free frame still bumps the count
                    usage[w][b] = 1'b0;
                    if (w < lowest_open_word)
                    begin
                        lowest_open_word = int'(w);
                    end
                    if (free_frames < FRAMES)
                    begin
                        free_frames++;
                    end
                end
            end
            want.free_count = COUNT_W'(free_frames);
            owed_rsp.push_back(want);
        endfunction

        task check_response(bpfa_rsp_t got);
            bpfa_rsp_t want;
            if (owed_rsp.size() == 0)
            begin
                report_mismatch($sformatf("response beat %h with nothing owed", got));
                return;
            end
            want = owed_rsp.pop_front();
            if (got.alloc_address !== want.alloc_address)
            begin
                report_mismatch($sformatf("alloc_address %h, wanted %h",
                                          got.alloc_address, want.alloc_address));
            end
            if (got.found !== want.found)
            begin
                report_mismatch($sformatf("found %b, wanted %b", got.found, want.found));
            end
            if (got.free_count !== want.free_count)
            begin
                report_mismatch($sformatf("free_count %0d, wanted %0d",
                                          got.free_count, want.free_count));
            end
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    bpfa_req_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    bpfa_rsp_t rsp;

    // idling odds per cycle, in percent, set per phase
    int unsigned sender_idle_pct;
    int unsigned rcvr_stall_pct;
    // frame number around which one class of frees clusters, moved per phase
    int unsigned hot_frame_base;
    int unsigned cycles = 0;

    frame_alloc_scoreboard sb;

    bitmap_page_frame_allocator #(
        .BITMAP_WORDS (WORDS),
        .FRAME_BYTES  (FRAME_SZ)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: ready is redrawn at every falling edge
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rcvr_stall_pct);
    end

    // monitor: responses first, since a response never belongs to a request
    // taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            begin
                sb.check_response(rsp);
            end
            if (req_valid === 1'b1 && req_ready === 1'b1)
            begin
                sb.note_request(req);
            end
        end
    end

    // present one request beat; entered and left at a falling edge
    task automatic send_request(bpfa_action_t act, logic [ADDR_W-1:0] addr);
        bpfa_req_t beat;
        beat.action        = act;
        beat.frame_address = addr;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (req_ready !== 1'b1)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // drop valid and hold off until every owed response has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // free addresses: low frames most often so allocations find them again,
    // a cluster at a random base, the very top, and anything at all
    function automatic logic [ADDR_W-1:0] pick_free_address();
        int unsigned       sel;
        logic [ADDR_W-1:0] frame;
        sel = $urandom_range(99);
        if (sel < 45)
        begin
            frame = $urandom_range(191);
        end
        else if (sel < 70)
        begin
            frame = hot_frame_base + $urandom_range(127);
        end
        else if (sel < 80)
        begin
            frame = FRAMES - 1 - $urandom_range(63);
        end
        else
        begin
            return $urandom();
        end
        return frame * FRAME_SZ + $urandom_range(FRAME_SZ - 1);
    endfunction

    // random traffic in bursts: free-heavy, alloc-heavy, mixed, and alloc runs
    // that, when few frames are free, use up every free frame and hit failure
    task automatic run_random(int unsigned beats);
        int unsigned sent;
        int unsigned kind;
        int unsigned run;
        int unsigned k;
        bit          is_alloc;
        sent = 0;
        while (sent < beats)
        begin
            kind = $urandom_range(9);
            run  = $urandom_range(12, 1);
            if (kind == 0)
            begin
                run = (sb.free_frames < 40) ? int'(sb.free_frames) + 3 : 40;
            end
            for (k = 0; k < run && sent < beats; k++)
            begin
                if (kind == 0)
                begin
                    is_alloc = 1'b1;
                end
                else if (kind < 4)
                begin
                    is_alloc = ($urandom_range(9) == 0);
                end
                else if (kind < 7)
                begin
                    is_alloc = ($urandom_range(9) < 8);
                end
                else
                begin
                    is_alloc = 1'($urandom_range(1));
                end
                if (is_alloc)
                begin
                    // the address is ignored for alloc, so it is noise here
                    send_request(ACT_ALLOC, $urandom());
                end
                else
                begin
                    send_request(ACT_FREE, pick_free_address());
                end
                sent++;
            end
        end
    endtask

    initial
    begin
        int unsigned p;
        sb              = new();
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req             = '0;
        rsp_ready       = 1'b0;
        sender_idle_pct = 0;
        rcvr_stall_pct  = 0;
        hot_frame_base  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every frame starts used, so the first alloc must fail
        send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_FREE,  32'h0000_0000);
        // frame 0 is a real frame: address 0 with found set
        send_request(ACT_ALLOC, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 32'h0000_0000);
        // top frame, offset bits all ones
        send_request(ACT_FREE,  32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 32'h0000_0000);
        // double free of frame 1 leaves the count one ahead of the bitmap
        send_request(ACT_FREE,  32'h0000_1FFF);
        send_request(ACT_FREE,  32'h0000_1000);
        send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_ALLOC, 32'h0000_0000);
        // word boundary and the middle of the address space
        send_request(ACT_FREE,  32'h0004_0ABC);
        send_request(ACT_FREE,  32'h0003_F000);
        send_request(ACT_FREE,  32'h8000_0000);
        send_request(ACT_FREE,  32'h7FFF_FFFF);
        send_request(ACT_ALLOC, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_ALLOC, 32'h5555_5555);
        send_request(ACT_ALLOC, 32'hAAAA_AAAA);
        send_request(ACT_ALLOC, 32'h0000_0000);
        // alternating bit patterns through the free path
        send_request(ACT_FREE,  32'h5555_5555);
        send_request(ACT_FREE,  32'hAAAA_AAAA);
        send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_ALLOC, 32'h0000_0000);
        wait_drained();

        // phases: no idling, sender idle, receiver stalling, both lightly
        for (p = 0; p < PHASES; p++)
        begin
            sender_idle_pct = (p == 1) ? 74 : (p == 3) ? 13 : 0;
            rcvr_stall_pct  = (p == 2) ? 74 : (p == 3) ? 13 : 0;
            hot_frame_base  = $urandom_range(FRAMES - 128);
            run_random(RANDOM_BEATS / PHASES);
            // sender holds back until the block has answered everything
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/bpfa_pkg.sv
rtl/bitmap_page_frame_allocator.sv
dv/tb.sv
